FILE: rtl/slx_pkg.sv
// shared types, codes and byte classification for the source text lexer
`timescale 1ns / 1ps

package slx_pkg;

	// width of the line and column counters, which saturate at all ones
	localparam int POS_BITS = 16;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_R  = 8'h72;

	typedef enum logic [3:0] {
		KIND_UNKNOWN  = 4'd0,
		KIND_IDENT    = 4'd1,
		KIND_NUMBER   = 4'd2,
		KIND_STRING   = 4'd3,
		KIND_OPERATOR = 4'd4,
		KIND_DELIM    = 4'd5,
		KIND_NEWLINE  = 4'd6,
		KIND_SPACE    = 4'd7,
		KIND_COMMENT  = 4'd8
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  src_byte;
		logic [7:0]  value_byte;
		logic        in_value;
		logic        token_first;
		logic        token_last;
		logic [3:0]  token_kind;
		logic [15:0] start_line;
		logic [15:0] start_column;
	} out_item_t;

	typedef struct packed {
		logic is_nl;
		logic is_space;
		logic is_digit;
		logic is_alpha;
		logic is_word;
		logic is_op;
		logic is_delim;
		logic is_sign;
		logic is_dot;
		logic is_hash;
		logic is_slash;
		logic is_star;
		logic is_dquote;
		logic is_squote;
		logic is_bslash;
		logic is_under;
	} char_class_t;

	// one emit step for the back end: the byte, its lookahead and what follows
	typedef struct packed {
		logic [7:0]  cur_byte;
		char_class_t cur_cls;
		logic [7:0]  next_byte;
		char_class_t next_cls;
		logic        has_next;
		logic        tail;      // a second, final step for next_byte follows
	} job_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		r.is_nl     = (c == CH_NL);
		r.is_space  = (c == CH_SP) || (c == CH_TAB) || (c == CH_NL) || (c == CH_VT) ||
		              (c == CH_FF) || (c == CH_CR);
		r.is_digit  = (c >= 8'h30) && (c <= 8'h39);
		r.is_alpha  = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
		r.is_under  = (c == CH_UNDER);
		r.is_word   = r.is_alpha || r.is_digit || r.is_under;
		r.is_op     = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
		              (c == CH_SLASH) || (c == 8'h3D) || (c == 8'h3C) || (c == 8'h3E) ||
		              (c == 8'h21) || (c == 8'h26) || (c == 8'h7C) || (c == 8'h5E) ||
		              (c == 8'h25) || (c == CH_TILDE);
		r.is_delim  = (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
		              (c == 8'h5B) || (c == 8'h5D) || (c == 8'h3B) || (c == 8'h3A) ||
		              (c == 8'h2C) || (c == CH_DOT);
		r.is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
		r.is_dot    = (c == CH_DOT);
		r.is_hash   = (c == CH_HASH);
		r.is_slash  = (c == CH_SLASH);
		r.is_star   = (c == CH_STAR);
		r.is_dquote = (c == CH_DQUOTE);
		r.is_squote = (c == CH_SQUOTE);
		r.is_bslash = (c == CH_BSLASH);
		return r;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c == CH_LOW_N) r = CH_NL;
		else if (c == CH_LOW_T) r = CH_TAB;
		else if (c == CH_LOW_R) r = CH_CR;
		return r;
	endfunction

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (&v) ? v : v + POS_BITS'(1);
	endfunction

endpackage

FILE: rtl/slx_front.sv
// front end: holds one byte of lookahead and turns input items into emit jobs
`timescale 1ns / 1ps

module slx_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  slx_pkg::in_item_t in_data,
	output logic             push,
	output slx_pkg::job_t    push_job,
	input  logic             push_ready
);
	import slx_pkg::*;

	logic [7:0]  held_byte_q;
	logic        held_valid_q;
	logic        accept;
	char_class_t in_cls;
	char_class_t held_cls;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign in_cls   = classify(in_data.in_byte);
	assign held_cls = classify(held_byte_q);

	// a held byte is emitted with the new byte as lookahead; a lone final byte has none
	assign push = accept && (held_valid_q || in_data.end_of_input);

	always_comb begin
		if (held_valid_q) begin
			push_job.cur_byte  = held_byte_q;
			push_job.cur_cls   = held_cls;
			push_job.has_next  = 1'b1;
			push_job.tail      = in_data.end_of_input;
		end else begin
			push_job.cur_byte  = in_data.in_byte;
			push_job.cur_cls   = in_cls;
			push_job.has_next  = 1'b0;
			push_job.tail      = 1'b0;
		end
		push_job.next_byte = in_data.in_byte;
		push_job.next_cls  = in_cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (accept) begin
			held_valid_q <= !in_data.end_of_input;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_byte_q <= in_data.in_byte;
		end
	end

endmodule

FILE: rtl/slx_queue.sv
// two-entry job queue between the front and back ends
`timescale 1ns / 1ps

module slx_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  slx_pkg::job_t push_job,
	output logic          push_ready,
	output logic          pop_valid,
	output slx_pkg::job_t pop_job,
	input  logic          pop
);
	import slx_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

FILE: rtl/slx_back.sv
// back end: token state machine, position counters and the output register
`timescale 1ns / 1ps

module slx_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  slx_pkg::job_t      job,
	output logic               job_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output slx_pkg::out_item_t out_data
);
	import slx_pkg::*;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'd0,
		MODE_SPACE  = 4'd1,
		MODE_LINE   = 4'd2,
		MODE_BOPEN  = 4'd3,
		MODE_BODY   = 4'd4,
		MODE_BCLOSE = 4'd5,
		MODE_STRING = 4'd6,
		MODE_NUMBER = 4'd7,
		MODE_IDENT  = 4'd8
	} mode_t;

	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

	mode_t               mode_q, mode_n, run_mode;
	logic                single_q, single_n;
	logic                esc_q, esc_n;
	logic                digit_q, digit_n;
	logic                dot_q, dot_n;
	logic                sign_q, sign_n;
	logic [POS_BITS-1:0] line_q, line_n;
	logic [POS_BITS-1:0] col_q, col_n;
	logic [POS_BITS-1:0] tok_line_q, tok_line_n;
	logic [POS_BITS-1:0] tok_col_q, tok_col_n;
	logic                phase_q;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic                fire;
	logic [7:0]          b;
	char_class_t         cb, cn;
	logic                nv;
	logic                first, last, inv;
	logic [7:0]          val;
	kind_t               kind;
	logic                num_on;
	kind_t               num_kind;
	out_item_t           res;

	assign fire    = job_valid && (!out_valid_q || out_ready);
	assign job_pop = fire && (phase_q || !job.tail);

	// the tail step replays the lookahead byte as the final byte
	assign b  = phase_q ? job.next_byte : job.cur_byte;
	assign cb = phase_q ? job.next_cls : job.cur_cls;
	assign nv = phase_q ? 1'b0 : job.has_next;
	assign cn = job.next_cls;

	always_comb begin
		first      = 1'b0;
		last       = 1'b1;
		inv        = 1'b1;
		val        = b;
		kind       = KIND_UNKNOWN;
		mode_n     = mode_q;
		single_n   = single_q;
		esc_n      = esc_q;
		digit_n    = digit_q;
		dot_n      = dot_q;
		sign_n     = sign_q;
		tok_line_n = tok_line_q;
		tok_col_n  = tok_col_q;
		num_on     = 1'b0;
		num_kind   = KIND_UNKNOWN;

		if (mode_q == MODE_IDLE) begin
			first      = 1'b1;
			tok_line_n = line_q;
			tok_col_n  = col_q;
			digit_n    = 1'b0;
			dot_n      = 1'b0;
			sign_n     = 1'b0;
			esc_n      = 1'b0;
			if (cb.is_nl) begin
				kind = KIND_NEWLINE;
			end else if (cb.is_space) begin
				mode_n = MODE_SPACE;
			end else if (cb.is_hash || (cb.is_slash && nv && cn.is_slash)) begin
				mode_n = MODE_LINE;
			end else if (cb.is_slash && nv && cn.is_star) begin
				mode_n = MODE_BOPEN;
				last   = 1'b0;
				kind   = KIND_COMMENT;
			end else if (cb.is_dquote || cb.is_squote) begin
				mode_n   = MODE_STRING;
				single_n = cb.is_squote;
				inv      = 1'b0;
				val      = 8'h00;
				last     = !nv;
			end else if (cb.is_digit || cb.is_sign || cb.is_dot) begin
				mode_n  = MODE_NUMBER;
				digit_n = cb.is_digit;
				dot_n   = cb.is_dot;
				sign_n  = cb.is_sign;
				num_on  = nv && (cn.is_digit || (cn.is_dot && !cb.is_dot));
				last    = !num_on;
				kind    = cb.is_digit ? KIND_NUMBER : (cb.is_sign ? KIND_OPERATOR : KIND_DELIM);
			end else if (cb.is_alpha || cb.is_under) begin
				mode_n = MODE_IDENT;
			end else if (cb.is_op) begin
				kind = KIND_OPERATOR;
			end else if (cb.is_delim) begin
				kind = KIND_DELIM;
			end
		end

		// whitespace, line comments and identifiers go on through the running logic
		if (mode_q != MODE_IDLE) begin
			run_mode = mode_q;
		end else if (mode_n == MODE_SPACE || mode_n == MODE_LINE || mode_n == MODE_IDENT) begin
			run_mode = mode_n;
		end else begin
			run_mode = MODE_IDLE;
		end

		unique case (run_mode)
			MODE_IDLE: begin
			end
			MODE_SPACE: begin
				last = !(nv && cn.is_space && !cn.is_nl);
				kind = KIND_SPACE;
			end
			MODE_LINE: begin
				last = !(nv && !cn.is_nl);
				kind = KIND_COMMENT;
			end
			MODE_BOPEN: begin
				mode_n = MODE_BODY;
				last   = !nv;
				kind   = KIND_COMMENT;
			end
			MODE_BODY: begin
				if (cb.is_star && nv && cn.is_slash) begin
					mode_n = MODE_BCLOSE;
					last   = 1'b0;
				end else begin
					last = !nv;
				end
				kind = KIND_COMMENT;
			end
			MODE_BCLOSE: begin
				last = 1'b1;
				kind = KIND_COMMENT;
			end
			MODE_STRING: begin
				if (esc_n) begin
					esc_n = 1'b0;
					val   = unescape(b);
					last  = !nv;
				end else if (single_n ? cb.is_squote : cb.is_dquote) begin
					inv  = 1'b0;
					val  = 8'h00;
					last = 1'b1;
					kind = KIND_STRING;
				end else if (cb.is_bslash && nv) begin
					esc_n = 1'b1;
					inv   = 1'b0;
					val   = 8'h00;
					last  = 1'b0;
				end else begin
					last = !nv;
				end
			end
			MODE_NUMBER: begin
				if (cb.is_digit) digit_n = 1'b1;
				if (cb.is_dot) dot_n = 1'b1;
				num_on   = nv && (cn.is_digit || (cn.is_dot && !dot_n));
				num_kind = digit_n ? KIND_NUMBER : (sign_n ? KIND_OPERATOR : KIND_DELIM);
				last     = !num_on;
				kind     = num_kind;
			end
			MODE_IDENT: begin
				last = !(nv && cn.is_word);
				kind = KIND_IDENT;
			end
			default: begin
				last = 1'b1;
			end
		endcase

		if (last) mode_n = MODE_IDLE;

		res.src_byte     = b;
		res.value_byte   = val;
		res.in_value     = inv;
		res.token_first  = first;
		res.token_last   = last;
		res.token_kind   = last ? kind : KIND_UNKNOWN;
		res.start_line   = 16'(tok_line_n);
		res.start_column = 16'(tok_col_n);

		if (cb.is_nl) begin
			line_n = sat_inc(line_q);
			col_n  = POS_ONE;
		end else begin
			line_n = line_q;
			col_n  = sat_inc(col_q);
		end

		// the final byte of a text returns everything to the reset state
		if (!nv) begin
			mode_n     = MODE_IDLE;
			single_n   = 1'b0;
			esc_n      = 1'b0;
			digit_n    = 1'b0;
			dot_n      = 1'b0;
			sign_n     = 1'b0;
			line_n     = POS_ONE;
			col_n      = POS_ONE;
			tok_line_n = POS_ONE;
			tok_col_n  = POS_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			single_q    <= 1'b0;
			esc_q       <= 1'b0;
			digit_q     <= 1'b0;
			dot_q       <= 1'b0;
			sign_q      <= 1'b0;
			line_q      <= POS_ONE;
			col_q       <= POS_ONE;
			tok_line_q  <= POS_ONE;
			tok_col_q   <= POS_ONE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (fire) begin
				mode_q      <= mode_n;
				single_q    <= single_n;
				esc_q       <= esc_n;
				digit_q     <= digit_n;
				dot_q       <= dot_n;
				sign_q      <= sign_n;
				line_q      <= line_n;
				col_q       <= col_n;
				tok_line_q  <= tok_line_n;
				tok_col_q   <= tok_col_n;
				phase_q     <= !phase_q && job.tail;
				out_valid_q <= 1'b1;
				out_data_q  <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/source_text_lexer.sv
// top level of the streaming source text lexer
//
// Input channel (in_valid/in_ready/in_data) takes one byte of source text per
// item; end_of_input marks the final byte of a text. Output channel
// (out_valid/out_ready/out_data) gives one result item per source byte, in
// order, tagged with token boundaries, kind, decoded value and start position.
// A byte is answered once the byte after it has been accepted, because the
// tokenizer looks one byte ahead; the final byte is answered right behind its
// predecessor, so a final item yields up to two results.
// With an idle pipe, the item that completes a result is written into the queue
// and then into the output register, where the result can be taken.
// One byte per cycle is sustained while out_ready stays high; a final byte that
// follows a held byte costs the back end an extra tail step.
// The front end holds the lookahead byte and classifies, a two-entry queue
// decouples it from the back end, which runs the token state machine and
// drives a registered output. When out_ready is low the output item holds,
// the back end stops, and in_ready drops only once the queue is full.
// Reset clears all token state and sets line and column to 1; the same
// happens after each final byte, so the next text starts fresh.
`timescale 1ns / 1ps

module source_text_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  slx_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output slx_pkg::out_item_t out_data
);
	import slx_pkg::*;

	logic push;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop;
	job_t pop_job;

	slx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	slx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop        (pop)
	);

	slx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job       (pop_job),
		.job_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
